// ===== sv/ksd_pkg.sv =====
// Shared constants, types and elaboration helpers of the k-mer substring distance block.
package ksd_pkg;

    localparam int KMER_W        = 64;
    localparam int DIST_W        = 6;
    localparam int RUN_W         = 6;
    localparam int SCORE_W       = 10;
    localparam int MAX_BASES_DEF = 32;
    localparam int GROUP         = 8;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic [DIST_W-1:0] KLEN_RST = 6'd32;
    localparam logic [DIST_W-1:0] NO_HIT   = '1;
    localparam logic              REG_KLEN = 1'b0;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] k;
    } t_ctl;

    // number of min levels, each folding GROUP entries into one
    function automatic int red_levels(input int n);
        int c;
        int l;
        c = n;
        l = 0;
        while (c > 1) begin
            c = (c + GROUP - 1) / GROUP;
            l = l + 1;
        end
        return l;
    endfunction

    // entries left after l min levels
    function automatic int red_cnt(input int n, input int l);
        int c;
        c = n;
        for (int s = 0; s < l; s++) begin
            c = (c + GROUP - 1) / GROUP;
        end
        return c;
    endfunction

endpackage

// ===== sv/ksd_match.sv =====
// Base compare stage: one match bit per table cell inside the k x k window.
module ksd_match #(
    parameter int MAX_BASES = ksd_pkg::MAX_BASES_DEF
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_en,
    input  ksd_pkg::t_ctl                                       i_ctl,
    input  logic [ksd_pkg::KMER_W-1:0]                          i_src,
    input  logic [ksd_pkg::KMER_W-1:0]                          i_tgt,
    output ksd_pkg::t_ctl                                       o_ctl,
    output logic [MAX_BASES-1:0][MAX_BASES-1:0][ksd_pkg::RUN_W-1:0] o_run
);

    ksd_pkg::t_ctl r_ctl;
    logic [MAX_BASES-1:0][MAX_BASES-1:0][ksd_pkg::RUN_W-1:0] r_run;
    logic [MAX_BASES-1:0][MAX_BASES-1:0][ksd_pkg::RUN_W-1:0] n_run;

    for (genvar gi = 0; gi < MAX_BASES; gi++) begin : g_row
        for (genvar gj = 0; gj < MAX_BASES; gj++) begin : g_col
            always_comb begin
                n_run[gi][gj] = '0;
                n_run[gi][gj][0] = (ksd_pkg::DIST_W'(gi) < i_ctl.k)
                                 && (ksd_pkg::DIST_W'(gj) < i_ctl.k)
                                 && (i_src[2*gi +: 2] == i_tgt[2*gj +: 2]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_run <= n_run;
        end
    end

    assign o_ctl = r_ctl;
    assign o_run = r_run;

endmodule

// ===== sv/ksd_run_step.sv =====
// One doubling step of the diagonal run length, capped at twice the incoming span.
module ksd_run_step #(
    parameter int MAX_BASES = ksd_pkg::MAX_BASES_DEF,
    parameter int STEP      = 0
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_en,
    input  ksd_pkg::t_ctl                                       i_ctl,
    input  logic [MAX_BASES-1:0][MAX_BASES-1:0][ksd_pkg::RUN_W-1:0] i_run,
    output ksd_pkg::t_ctl                                       o_ctl,
    output logic [MAX_BASES-1:0][MAX_BASES-1:0][ksd_pkg::RUN_W-1:0] o_run
);

    localparam int SH = 1 << STEP;

    ksd_pkg::t_ctl r_ctl;
    logic [MAX_BASES-1:0][MAX_BASES-1:0][ksd_pkg::RUN_W-1:0] r_run;
    logic [MAX_BASES-1:0][MAX_BASES-1:0][ksd_pkg::RUN_W-1:0] n_run;

    for (genvar gi = 0; gi < MAX_BASES; gi++) begin : g_row
        for (genvar gj = 0; gj < MAX_BASES; gj++) begin : g_col
            if (gi >= SH && gj >= SH) begin : g_ext
                // a full span extends by the run that ends one span up the diagonal
                assign n_run[gi][gj] = (i_run[gi][gj] == ksd_pkg::RUN_W'(SH))
                    ? ksd_pkg::RUN_W'(SH) + i_run[gi-SH][gj-SH]
                    : i_run[gi][gj];
            end else begin : g_edge
                assign n_run[gi][gj] = i_run[gi][gj];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_run <= n_run;
        end
    end

    assign o_ctl = r_ctl;
    assign o_run = r_run;

endmodule

// ===== sv/ksd_score.sv =====
// Per-cell distance from the run length; cells without a usable distance give the no-hit code.
module ksd_score #(
    parameter int MAX_BASES = ksd_pkg::MAX_BASES_DEF
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_en,
    input  ksd_pkg::t_ctl                                       i_ctl,
    input  logic [MAX_BASES-1:0][MAX_BASES-1:0][ksd_pkg::RUN_W-1:0] i_run,
    output ksd_pkg::t_ctl                                       o_ctl,
    output logic [MAX_BASES*MAX_BASES-1:0][ksd_pkg::DIST_W-1:0] o_dist
);

    localparam int SW = ksd_pkg::SCORE_W;

    ksd_pkg::t_ctl r_ctl;
    logic [MAX_BASES*MAX_BASES-1:0][ksd_pkg::DIST_W-1:0] r_dist;
    logic [MAX_BASES*MAX_BASES-1:0][ksd_pkg::DIST_W-1:0] n_dist;

    for (genvar gi = 0; gi < MAX_BASES; gi++) begin : g_row
        for (genvar gj = 0; gj < MAX_BASES; gj++) begin : g_col
            logic signed [SW-1:0] c;
            logic signed [SW-1:0] k;
            logic signed [SW-1:0] rest;
            logic signed [SW-1:0] ms;
            logic signed [SW-1:0] mt;
            logic signed [SW-1:0] d;
            logic                 use_rest;

            always_comb begin
                c    = SW'(i_run[gi][gj]);
                k    = SW'(i_ctl.k);
                rest = k - SW'(gi) - c;
                // a negative rest fails the sign check on rest, so i wins the min
                use_rest = (rest >= 0) && !(SW'(gi) < rest);
                ms = use_rest ? rest : SW'(gi);
                mt = (use_rest && (rest < SW'(gi))) ? SW'(gj) : (k - SW'(gj) - c);
                d  = ms + (k - c) + mt;
                if (i_run[gi][gj] == '0 || d < 0 || d > SW'(ksd_pkg::NO_HIT)) begin
                    n_dist[gi*MAX_BASES+gj] = ksd_pkg::NO_HIT;
                end else begin
                    n_dist[gi*MAX_BASES+gj] = d[ksd_pkg::DIST_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist <= n_dist;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_dist = r_dist;

endmodule

// ===== sv/ksd_min_stage.sv =====
// One registered level of the min tree, folding each group of entries into one.
module ksd_min_stage #(
    parameter int N_IN = 8
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_en,
    input  ksd_pkg::t_ctl                                      i_ctl,
    input  logic [N_IN-1:0][ksd_pkg::DIST_W-1:0]               i_v,
    output ksd_pkg::t_ctl                                      o_ctl,
    output logic [(N_IN+ksd_pkg::GROUP-1)/ksd_pkg::GROUP-1:0][ksd_pkg::DIST_W-1:0] o_v
);

    localparam int N_OUT = (N_IN + ksd_pkg::GROUP - 1) / ksd_pkg::GROUP;

    ksd_pkg::t_ctl r_ctl;
    logic [N_OUT-1:0][ksd_pkg::DIST_W-1:0] r_v;
    logic [N_OUT-1:0][ksd_pkg::DIST_W-1:0] n_v;

    for (genvar g = 0; g < N_OUT; g++) begin : g_grp
        always_comb begin
            n_v[g] = ksd_pkg::NO_HIT;
            for (int e = 0; e < ksd_pkg::GROUP; e++) begin
                if (g*ksd_pkg::GROUP + e < N_IN) begin
                    if (i_v[g*ksd_pkg::GROUP + e] < n_v[g]) begin
                        n_v[g] = i_v[g*ksd_pkg::GROUP + e];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
        end
    end

    assign o_ctl = r_ctl;
    assign o_v   = r_v;

endmodule

// ===== sv/kmer_substring_distance.sv =====
// Throughput: one k-mer pair per cycle; the whole pipeline holds while a finished beat waits.
// Each table cell owns its compare, run length and distance logic; a run length is built
// by doubling steps, one register stage each, and the min is taken eight entries per stage.
// Reset empties the pipeline and sets the base count register to 32; no clearing pass is needed.
module kmer_substring_distance #(
    parameter int MAX_BASES = ksd_pkg::MAX_BASES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ksd_pkg::KMER_W-1:0]        i_source_kmer,
    input  logic [ksd_pkg::KMER_W-1:0]        i_target_kmer,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ksd_pkg::DIST_W-1:0]        o_distance,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ksd_pkg::ADDR_W-1:0]        paddr,
    input  logic [ksd_pkg::DATA_W-1:0]        pwdata,
    output logic [ksd_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    localparam int NS = $clog2(MAX_BASES);
    localparam int N  = MAX_BASES * MAX_BASES;
    localparam int NL = ksd_pkg::red_levels(N);

    logic [ksd_pkg::DIST_W-1:0] r_klen;
    logic                       r_out_valid;
    logic [ksd_pkg::DIST_W-1:0] r_dist;
    logic [ksd_pkg::DIST_W-1:0] n_dist;
    logic                       en;
    logic                       cfg_wr;
    ksd_pkg::t_ctl              in_ctl;

    ksd_pkg::t_ctl ctl_run [NS+1];
    logic [MAX_BASES-1:0][MAX_BASES-1:0][ksd_pkg::RUN_W-1:0] run [NS+1];
    ksd_pkg::t_ctl ctl_lv [NL+1];
    logic [N-1:0][ksd_pkg::DIST_W-1:0] lv [NL+1];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[ksd_pkg::ADDR_W-1] == ksd_pkg::REG_KLEN);
    assign prdata = (paddr[ksd_pkg::ADDR_W-1] == ksd_pkg::REG_KLEN)
                  ? ksd_pkg::DATA_W'(r_klen) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen <= ksd_pkg::KLEN_RST;
        end else if (cfg_wr) begin
            r_klen <= pwdata[ksd_pkg::DIST_W-1:0];
        end
    end

    // advance the whole pipeline unless a finished beat is held
    assign en      = i_ready || !r_out_valid;
    assign o_ready = en;

    always_comb begin
        in_ctl.valid = i_valid;
        in_ctl.k     = (r_klen > ksd_pkg::DIST_W'(MAX_BASES))
                     ? ksd_pkg::DIST_W'(MAX_BASES) : r_klen;
    end

    ksd_match #(.MAX_BASES(MAX_BASES)) u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (in_ctl),
        .i_src   (i_source_kmer),
        .i_tgt   (i_target_kmer),
        .o_ctl   (ctl_run[0]),
        .o_run   (run[0])
    );

    for (genvar s = 0; s < NS; s++) begin : g_step
        ksd_run_step #(.MAX_BASES(MAX_BASES), .STEP(s)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl_run[s]),
            .i_run   (run[s]),
            .o_ctl   (ctl_run[s+1]),
            .o_run   (run[s+1])
        );
    end

    ksd_score #(.MAX_BASES(MAX_BASES)) u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (ctl_run[NS]),
        .i_run   (run[NS]),
        .o_ctl   (ctl_lv[0]),
        .o_dist  (lv[0])
    );

    for (genvar l = 0; l < NL; l++) begin : g_lvl
        localparam int CIN  = ksd_pkg::red_cnt(N, l);
        localparam int COUT = ksd_pkg::red_cnt(N, l + 1);

        ksd_min_stage #(.N_IN(CIN)) u_min (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl_lv[l]),
            .i_v     (lv[l][CIN-1:0]),
            .o_ctl   (ctl_lv[l+1]),
            .o_v     (lv[l+1][COUT-1:0])
        );

        if (COUT < N) begin : g_pad
            assign lv[l+1][N-1:COUT] = '1;
        end
    end

    // the search starts from k, so k caps the result
    assign n_dist = (lv[NL][0] < ctl_lv[NL].k) ? lv[NL][0] : ctl_lv[NL].k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= ctl_lv[NL].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist <= n_dist;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_distance = r_dist;

    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_distance <= ksd_pkg::DIST_W'(MAX_BASES)))
        else $error("distance above MAX_BASES");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_klen == $past(pwdata[ksd_pkg::DIST_W-1:0])))
        else $error("base count write lost");

    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && ctl_lv[NL].valid) |=> o_valid)
        else $error("pipeline beat dropped at output");

endmodule
